[hdl/tcmfp_pkg.sv]
package tcmfp_pkg;

    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 48;

    localparam int HEADER_BYTES = 5;
    localparam int HDR_CW       = 3;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [7:0] THRESHOLD_RESET  = 8'd128;
    localparam logic [7:0] CMD_WRITE_MEMORY = 8'h08;
    localparam logic [7:0] HDR_ZERO         = 8'h00;

    localparam logic REG_LIT_THRESHOLD = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic fetch;
    } dp_cmd_t;

    function automatic logic [7:0] header_byte(
        input logic [HDR_CW-1:0] idx,
        input logic [7:0]        width_m1,
        input logic [7:0]        strips_m1
    );
        logic [7:0] b;
        b = strips_m1;
        unique case (idx)
            3'd0:    b = CMD_WRITE_MEMORY;
            3'd1:    b = HDR_ZERO;
            3'd2:    b = HDR_ZERO;
            3'd3:    b = width_m1;
            default: b = strips_m1;
        endcase
        return b;
    endfunction

endpackage

[hdl/threshold_column_major_frame_packer_core.sv]
// thresholds 8-bit pixels into a 1 bit per dot frame store packed column-major,
// then reads the store back as a header plus packed bytes
//
// input channel: in_valid / in_stall with func and pixel; func 0 loads the next
// row-major pixel, func 1 fetches the next output byte
// output channel: out_valid / out_stall with out_byte, is_header, last; one item
// per fetch, none per load
// a readout is five header bytes (0x08, 0, 0, width-1, strips-1) then every
// packed byte, last high on the final one; the readout then starts over
// apb port: lit_threshold at address 0, pready always high
//
// latency: a fetch result is valid in the cycle after the fetch is accepted
// throughput: one item per cycle unless stalled; a load is a single bit write
// into the store and a fetch a single byte read from its registered read port
// receiver stall: the result holds in its register and in_stall is high for as
// long as out_stall holds off a pending result
// reset: threshold goes to 128, load and readout positions go to zero, no
// clearing pass; store contents are undefined until a frame is loaded
module threshold_column_major_frame_packer_core #(
    parameter int FRAME_WIDTH  = tcmfp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = tcmfp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [7:0]                     pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           is_header,
    output logic                           last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcmfp_pkg::APB_AW-1:0]   paddr,
    input  logic [tcmfp_pkg::APB_DW-1:0]   pwdata,
    output logic [tcmfp_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);

    tcmfp_pkg::dp_cmd_t cmd;

    assign pready = 1'b1;

    tcmfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    tcmfp_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pixel     (pixel),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .out_byte  (out_byte),
        .is_header (is_header),
        .last      (last)
    );

endmodule

[hdl/tcmfp_ctrl.sv]
module tcmfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               func,
    input  logic               out_stall,
    output logic               in_stall,
    output logic               out_valid,
    output tcmfp_pkg::dp_cmd_t cmd
);

    tcmfp_pkg::ctl_state_t state_reg;
    tcmfp_pkg::ctl_state_t state_next;
    logic                  accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcmfp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall  = (state_reg == tcmfp_pkg::ST_RESP) && out_stall;
        out_valid = (state_reg == tcmfp_pkg::ST_RESP);
        accept    = in_valid && !in_stall;
        cmd.load  = accept && !func;
        cmd.fetch = accept && func;
        state_next = state_reg;
        unique case (state_reg)
            tcmfp_pkg::ST_IDLE:
            begin
                if (cmd.fetch)
                begin
                    state_next = tcmfp_pkg::ST_RESP;
                end
            end
            tcmfp_pkg::ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = cmd.fetch ? tcmfp_pkg::ST_RESP : tcmfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcmfp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/tcmfp_datapath.sv]
module tcmfp_datapath #(
    parameter int FRAME_WIDTH  = tcmfp_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = tcmfp_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcmfp_pkg::dp_cmd_t             cmd,
    input  logic [7:0]                     pixel,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcmfp_pkg::APB_AW-1:0]   paddr,
    input  logic [tcmfp_pkg::APB_DW-1:0]   pwdata,
    output logic [tcmfp_pkg::APB_DW-1:0]   prdata,
    output logic [7:0]                     out_byte,
    output logic                           is_header,
    output logic                           last
);

    localparam int STRIPS      = (FRAME_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = FRAME_WIDTH * STRIPS;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(FRAME_WIDTH);
    localparam int RW          = $clog2(FRAME_HEIGHT);
    localparam int SW          = (STRIPS > 1) ? $clog2(STRIPS) : 1;
    localparam int HW          = tcmfp_pkg::HDR_CW;
    localparam logic [7:0] TAIL_MASK =
        ((FRAME_HEIGHT % 8) == 0) ? 8'hFF : 8'((1 << (FRAME_HEIGHT % 8)) - 1);
    localparam logic [7:0] WIDTH_M1  = 8'(FRAME_WIDTH - 1);
    localparam logic [7:0] STRIPS_M1 = 8'(STRIPS - 1);

    logic [7:0]    mem [STORE_BYTES];

    logic [7:0]    thr_reg;
    logic [CW-1:0] col_reg,  col_next;
    logic [RW-1:0] row_reg,  row_next;
    logic [AW-1:0] base_reg, base_next;
    logic [HW-1:0] hdr_reg,  hdr_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic [SW-1:0] strip_reg, strip_next;

    logic [7:0]    rdata_reg;
    logic          resp_hdr_reg;
    logic [7:0]    resp_hbyte_reg;
    logic          resp_last_reg;
    logic          resp_tail_reg;

    logic [AW-1:0] waddr;
    logic [2:0]    wbit;
    logic          dot;
    logic          in_body;
    logic          at_end;
    logic          cfg_wr;

    // config register
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tcmfp_pkg::REG_LIT_THRESHOLD);
    assign prdata = (paddr[2] == tcmfp_pkg::REG_LIT_THRESHOLD) ?
                    {{(tcmfp_pkg::APB_DW - 8){1'b0}}, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tcmfp_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[7:0];
        end
    end

    // load address walk: row-major in, column-major store
    assign waddr = base_reg + AW'(row_reg >> 3);
    assign wbit  = row_reg[2:0];
    assign dot   = (pixel >= thr_reg);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (cmd.load)
        begin
            if (col_reg == CW'(FRAME_WIDTH - 1))
            begin
                col_next  = '0;
                base_next = '0;
                row_next  = (row_reg == RW'(FRAME_HEIGHT - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next  = col_reg + 1'b1;
                base_next = base_reg + AW'(STRIPS);
            end
        end
    end

    // readout walk
    assign in_body = (hdr_reg == HW'(tcmfp_pkg::HEADER_BYTES));
    assign at_end  = (raddr_reg == AW'(STORE_BYTES - 1));

    always_comb
    begin
        hdr_next   = hdr_reg;
        raddr_next = raddr_reg;
        strip_next = strip_reg;
        if (cmd.fetch)
        begin
            if (!in_body)
            begin
                hdr_next = hdr_reg + 1'b1;
            end
            else if (at_end)
            begin
                hdr_next   = '0;
                raddr_next = '0;
                strip_next = '0;
            end
            else
            begin
                raddr_next = raddr_reg + 1'b1;
                strip_next = (strip_reg == SW'(STRIPS - 1)) ? '0 : strip_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
            hdr_reg   <= '0;
            raddr_reg <= '0;
            strip_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            hdr_reg   <= hdr_next;
            raddr_reg <= raddr_next;
            strip_reg <= strip_next;
        end
    end

    // frame store, bit write and registered byte read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[waddr][wbit] <= dot;
        end
        if (cmd.fetch)
        begin
            rdata_reg <= mem[raddr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            resp_hdr_reg   <= !in_body;
            resp_hbyte_reg <= tcmfp_pkg::header_byte(hdr_reg, WIDTH_M1, STRIPS_M1);
            resp_last_reg  <= in_body && at_end;
            resp_tail_reg  <= (strip_reg == SW'(STRIPS - 1));
        end
    end

    assign out_byte  = resp_hdr_reg ? resp_hbyte_reg :
                       (rdata_reg & (resp_tail_reg ? TAIL_MASK : 8'hFF));
    assign is_header = resp_hdr_reg;
    assign last      = resp_last_reg;

endmodule

[hdl/tcmfp_checker.sv]
module tcmfp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     out_byte,
    input  logic                           is_header,
    input  logic                           last
);

    logic after_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_last_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            after_last_reg <= last;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_header && last))
        else $error("header byte marked last");

    a_stall_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    a_wrap_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_last_reg |->
            is_header && (out_byte == tcmfp_pkg::CMD_WRITE_MEMORY))
        else $error("readout did not restart at header");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without accepted item");

endmodule

bind threshold_column_major_frame_packer_core tcmfp_checker u_tcmfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_header (is_header),
    .last      (last)
);
